// ===== hdl/tccw_pkg.sv =====
// shared constants, codes and the job record for the text console cell writer
package tccw_pkg;

  localparam int COLS_MAX   = 128;
  localparam int ROWS_MAX   = 32;
  localparam int PAGES      = 8;
  localparam int RING_LINES = PAGES * ROWS_MAX;

  localparam int COL_W  = $clog2(COLS_MAX);
  localparam int ROW_W  = $clog2(ROWS_MAX);
  localparam int LINE_W = $clog2(RING_LINES);
  localparam int ADDR_W = LINE_W + COL_W;
  localparam int CHAR_W = 8;
  localparam int VAL_W  = 16;

  // job queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  // input op codes
  localparam logic [1:0] OP_CHAR   = 2'd0;
  localparam logic [1:0] OP_SETPOS = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_CELL     = 2'd0;
  localparam logic [1:0] KIND_CLR_LINE = 2'd1;
  localparam logic [1:0] KIND_CLR_ALL  = 2'd2;
  localparam logic [1:0] KIND_CURSOR   = 2'd3;

  // configuration register indexes
  localparam logic [1:0] REG_ATTR      = 2'd0;
  localparam logic [1:0] REG_TAB_SHIFT = 2'd1;
  localparam logic [1:0] REG_COLUMNS   = 2'd2;
  localparam logic [1:0] REG_ROWS      = 2'd3;

  // register reset values
  localparam logic [7:0] ATTR_RST      = 8'd7;
  localparam logic [2:0] TAB_SHIFT_RST = 3'd3;
  localparam logic [7:0] COLUMNS_RST   = 8'd80;
  localparam logic [5:0] ROWS_RST      = 6'd25;
  localparam logic [2:0] TAB_SHIFT_MAX = 3'd4;

  // character codes
  localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0d;
  localparam logic [CHAR_W-1:0] PRINT_LO = 8'h20;
  localparam logic [CHAR_W-1:0] PRINT_HI = 8'h7e;

  // one classified item: up to two result words
  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] cell_address;
    logic [VAL_W-1:0]  cell_value;
    logic [LINE_W-1:0] line_index;
    logic              dual;
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [LINE_W-1:0] view_top;
  } job_t;

endpackage

// ===== hdl/tccw_front.sv =====
// front end: config registers, cursor state and classification of each item
module tccw_front
  import tccw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_op,
  input  logic [CHAR_W-1:0] in_char,
  input  logic [COL_W-1:0]  in_col,
  input  logic [ROW_W-1:0]  in_row,
  input  logic              q_full,
  output logic              push,
  output job_t              push_job
);

  logic [7:0]        attr_r;
  logic [2:0]        tab_shift_r;
  logic [7:0]        columns_r;
  logic [5:0]        rows_r;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [LINE_W-1:0] top_r, top_nxt;

  logic [COL_W:0]    cols_eff, col_inc, tab_nc;
  logic [ROW_W:0]    rows_eff, row_inc;
  logic [2:0]        ts;
  logic [COL_W-1:0]  col_c, col_set;
  logic [ROW_W-1:0]  row_c, row_set, row_nr;
  logic [LINE_W-1:0] top_inc, top_nr, cleared, line;
  logic              wrap, scroll, printable;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign push      = in_valid && !q_full;

  always_comb begin
    if (columns_r == '0) cols_eff = (COL_W+1)'(1);
    else if (columns_r > 8'(COLS_MAX)) cols_eff = (COL_W+1)'(COLS_MAX);
    else cols_eff = (COL_W+1)'(columns_r);
    if (rows_r == '0) rows_eff = (ROW_W+1)'(1);
    else if (rows_r > 6'(ROWS_MAX)) rows_eff = (ROW_W+1)'(ROWS_MAX);
    else rows_eff = (ROW_W+1)'(rows_r);
    ts = (tab_shift_r > TAB_SHIFT_MAX) ? TAB_SHIFT_MAX : tab_shift_r;

    // geometry may have shrunk under the cursor
    col_c = ({1'b0, col_r} >= cols_eff) ? COL_W'(cols_eff - 1'b1) : col_r;
    row_c = ({1'b0, row_r} >= rows_eff) ? ROW_W'(rows_eff - 1'b1) : row_r;

    col_set = ({1'b0, in_col} >= cols_eff) ? COL_W'(cols_eff - 1'b1) : in_col;
    row_set = ({1'b0, in_row} >= rows_eff) ? ROW_W'(rows_eff - 1'b1) : in_row;

    col_inc = {1'b0, col_c} + 1'b1;
    wrap    = col_inc >= cols_eff;
    row_inc = {1'b0, row_c} + 1'b1;
    scroll  = row_inc >= rows_eff;
    top_inc = top_r + 1'b1;
    cleared = top_inc + LINE_W'(rows_eff - 1'b1);
    row_nr  = scroll ? ROW_W'(rows_eff - 1'b1) : ROW_W'(row_inc);
    top_nr  = scroll ? top_inc : top_r;
    line    = top_r + LINE_W'(row_c);
    tab_nc  = ((COL_W+1)'(col_c >> ts) + 1'b1) << ts;

    printable = (in_char >= PRINT_LO) && (in_char <= PRINT_HI);

    col_nxt = col_c;
    row_nxt = row_c;
    top_nxt = top_r;
    push_job.kind         = KIND_CURSOR;
    push_job.cell_address = '0;
    push_job.cell_value   = '0;
    push_job.line_index   = '0;
    push_job.dual         = 1'b0;

    unique case (in_op)
      OP_SETPOS: begin
        col_nxt = col_set;
        row_nxt = row_set;
      end
      OP_CLEAR: begin
        col_nxt = '0;
        row_nxt = '0;
        top_nxt = '0;
        push_job.kind = KIND_CLR_ALL;
      end
      OP_CHAR: begin
        if (printable) begin
          push_job.kind         = KIND_CELL;
          push_job.cell_address = {line, col_c};
          push_job.cell_value   = {attr_r, in_char};
          if (wrap) begin
            col_nxt = '0;
            row_nxt = row_nr;
            top_nxt = top_nr;
            if (scroll) begin
              push_job.dual       = 1'b1;
              push_job.line_index = cleared;
            end
          end else begin
            col_nxt = COL_W'(col_inc);
          end
        end else if (in_char == CH_LF) begin
          col_nxt = '0;
          row_nxt = row_nr;
          top_nxt = top_nr;
          if (scroll) begin
            push_job.kind       = KIND_CLR_LINE;
            push_job.line_index = cleared;
          end
        end else if (in_char == CH_BS) begin
          if (col_c != '0) col_nxt = col_c - 1'b1;
        end else if (in_char == CH_CR) begin
          col_nxt = '0;
        end else if (in_char == CH_TAB) begin
          col_nxt = (tab_nc >= cols_eff) ? COL_W'(cols_eff - 1'b1) : COL_W'(tab_nc);
        end
      end
      default: ;
    endcase

    push_job.cursor_col = col_nxt;
    push_job.cursor_row = row_nxt;
    push_job.view_top   = top_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attr_r      <= ATTR_RST;
      tab_shift_r <= TAB_SHIFT_RST;
      columns_r   <= COLUMNS_RST;
      rows_r      <= ROWS_RST;
      col_r       <= '0;
      row_r       <= '0;
      top_r       <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_ATTR:      attr_r      <= cfg_data;
          REG_TAB_SHIFT: tab_shift_r <= cfg_data[2:0];
          REG_COLUMNS:   columns_r   <= cfg_data;
          REG_ROWS:      rows_r      <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (push) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        top_r <= top_nxt;
      end
    end
  end

endmodule

// ===== hdl/tccw_queue.sv =====
// short job queue between the front and back ends
module tccw_queue
  import tccw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic full,
  output logic empty,
  output job_t head
);

  job_t              mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r;

  assign full  = count_r == (QPTR_W+1)'(QDEPTH);
  assign empty = count_r == '0;
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr_r] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

endmodule

// ===== hdl/tccw_back.sv =====
// back end: expands each job into one or two result words behind an output register
module tccw_back
  import tccw_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  job_t              head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_kind,
  output logic [ADDR_W-1:0] out_cell_address,
  output logic [VAL_W-1:0]  out_cell_value,
  output logic [LINE_W-1:0] out_line_index,
  output logic [COL_W-1:0]  out_cursor_col,
  output logic [ROW_W-1:0]  out_cursor_row,
  output logic [LINE_W-1:0] out_view_top,
  output logic              out_last
);

  logic              valid_r;
  logic              second_r;
  logic [1:0]        kind_r;
  logic [ADDR_W-1:0] addr_r;
  logic [VAL_W-1:0]  val_r;
  logic [LINE_W-1:0] line_r;
  logic [COL_W-1:0]  col_r;
  logic [ROW_W-1:0]  row_r;
  logic [LINE_W-1:0] top_r;
  logic              last_r;
  logic              load, take;

  assign load = !valid_r || out_ready;
  assign take = load && !q_empty;
  // a two-word job stays at the head until its second word is loaded into the output register
  assign pop  = take && (!head.dual || second_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      second_r <= 1'b0;
    end else if (load) begin
      valid_r  <= !q_empty;
      second_r <= take && head.dual && !second_r;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      col_r <= head.cursor_col;
      row_r <= head.cursor_row;
      top_r <= head.view_top;
      if (head.dual && !second_r) begin
        kind_r <= KIND_CELL;
        addr_r <= head.cell_address;
        val_r  <= head.cell_value;
        line_r <= '0;
        last_r <= 1'b0;
      end else if (head.dual) begin
        kind_r <= KIND_CLR_LINE;
        addr_r <= '0;
        val_r  <= '0;
        line_r <= head.line_index;
        last_r <= 1'b1;
      end else begin
        kind_r <= head.kind;
        addr_r <= head.cell_address;
        val_r  <= head.cell_value;
        line_r <= head.line_index;
        last_r <= 1'b1;
      end
    end
  end

  assign out_valid        = valid_r;
  assign out_kind         = kind_r;
  assign out_cell_address = addr_r;
  assign out_cell_value   = val_r;
  assign out_line_index   = line_r;
  assign out_cursor_col   = col_r;
  assign out_cursor_row   = row_r;
  assign out_view_top     = top_r;
  assign out_last         = last_r;

endmodule

// ===== hdl/text_console_cell_writer.sv =====
// an accepted item is written into the job queue, and from there loaded into the output register
// throughput: one item per cycle while the job queue is not full; a printable byte that scrolls gives two words
// the output register drains one word per cycle while out_tready is high; a four-deep job queue decouples the sides
// reset: cursor, view top and queue clear, registers return to their defaults,
// output goes idle at once; there is no clearing pass
module text_console_cell_writer
  import tccw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // char_code[7:0], new_col[14:8], new_row[19:15], zero
  input  logic [1:0]  in_tuser,   // op[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  // cell_address[14:0], cell_value[30:15], line_index[38:31], cursor_col[45:39],
  // cursor_row[50:46], view_top[58:51], zero
  output logic [63:0] out_tdata,
  output logic [1:0]  out_tuser,  // kind[1:0]
  output logic        out_tlast
);

  logic              push, pop, q_full, q_empty;
  job_t              push_job, head;
  logic [ADDR_W-1:0] o_addr;
  logic [VAL_W-1:0]  o_val;
  logic [LINE_W-1:0] o_line, o_top;
  logic [COL_W-1:0]  o_col;
  logic [ROW_W-1:0]  o_row;

  tccw_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_op    (in_tuser),
    .in_char  (in_tdata[7:0]),
    .in_col   (in_tdata[14:8]),
    .in_row   (in_tdata[19:15]),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  tccw_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .full    (q_full),
    .empty   (q_empty),
    .head    (head)
  );

  tccw_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_empty         (q_empty),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_tvalid),
    .out_ready       (out_tready),
    .out_kind        (out_tuser),
    .out_cell_address(o_addr),
    .out_cell_value  (o_val),
    .out_line_index  (o_line),
    .out_cursor_col  (o_col),
    .out_cursor_row  (o_row),
    .out_view_top    (o_top),
    .out_last        (out_tlast)
  );

  assign out_tdata = {5'd0, o_top, o_row, o_col, o_line, o_val, o_addr};

endmodule

// ===== hdl/tccw_checker.sv =====
// port-level checks on the result channel, bound to the top level
module tccw_checker
  import tccw_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);

  // output channel idle right after reset
  a_idle_after_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid right after reset");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser)
      && $stable(out_tlast))
    else $error("result word changed while stalled");

  // only the cell write of a scrolling character is followed by another word
  a_first_of_two: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> out_tuser == KIND_CELL)
    else $error("non-final word is not a cell write");

  a_clear_all_home: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_CLR_ALL |-> out_tdata[58:39] == '0 && out_tlast)
    else $error("clear-all did not home the cursor and view");

endmodule

bind text_console_cell_writer tccw_checker u_tccw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser),
  .out_tlast (out_tlast)
);

// ===== tb/sv/testbench.sv =====
// testbench for the text console cell writer: random and directed requests against a predictor
module testbench;
  import tccw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_NONE = 2'd3;  // op code with no meaning: cursor-only result
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned TAIL_CYCLES = 16;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] code;
    logic [6:0] col;
    logic [4:0] row;
  } request_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [ADDR_W-1:0] addr;
    logic [VAL_W-1:0]  val;
    logic [LINE_W-1:0] line;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [LINE_W-1:0] top;
    logic              last;
  } cell_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_ATTR;
  logic [7:0]  cfg_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;
  logic [1:0]  in_tuser = OP_CHAR;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  text_console_cell_writer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always #6 clk = ~clk;

  request_t   pending_requests[$];
  cell_word_t expected_words[$];
  request_t   on_bus;

  // predictor state and register copies
  int unsigned cur_col, cur_row, view_top_line;
  logic [7:0]  attr_reg = ATTR_RST;
  logic [2:0]  tab_reg = TAB_SHIFT_RST;
  logic [7:0]  cols_reg = COLUMNS_RST;
  logic [5:0]  rows_reg = ROWS_RST;

  int unsigned errors, requests_taken, words_seen, cell_writes, line_clears, screen_clears;
  int unsigned cycles;
  int unsigned holds_asked, holds_done, hold_left;
  bit          steady;

  function automatic bit advance_row(int unsigned nrows, output int unsigned cleared);
    cleared = 0;
    cur_row++;
    if (cur_row >= nrows) begin
      cur_row = nrows - 1;
      view_top_line = (view_top_line + 1) % RING_LINES;
      cleared = (view_top_line + nrows - 1) % RING_LINES;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void console_step(request_t rq);
    int unsigned cols, nrows, ts, line, nc;
    cell_word_t  w[2];
    int          n;
    cols  = (cols_reg == 0) ? 1 : (cols_reg > COLS_MAX) ? COLS_MAX : cols_reg;
    nrows = (rows_reg == 0) ? 1 : (rows_reg > ROWS_MAX) ? ROWS_MAX : rows_reg;
    ts    = (tab_reg > TAB_SHIFT_MAX) ? TAB_SHIFT_MAX : tab_reg;
    n = 1;
    w[0] = '0;
    w[1] = '0;
    // geometry may have shrunk under the cursor
    if (cur_col >= cols) cur_col = cols - 1;
    if (cur_row >= nrows) cur_row = nrows - 1;
    if (rq.op == OP_SETPOS) begin
      cur_col = (rq.col >= cols) ? cols - 1 : rq.col;
      cur_row = (rq.row >= nrows) ? nrows - 1 : rq.row;
      w[0].kind = KIND_CURSOR;
    end else if (rq.op == OP_CLEAR) begin
      cur_col = 0;
      cur_row = 0;
      view_top_line = 0;
      w[0].kind = KIND_CLR_ALL;
      screen_clears++;
    end else if (rq.op == OP_CHAR && rq.code >= PRINT_LO && rq.code <= PRINT_HI) begin
      line = (view_top_line + cur_row) % RING_LINES;
      w[0].kind = KIND_CELL;
      w[0].addr = ADDR_W'(line * COLS_MAX + cur_col);
      w[0].val  = {attr_reg, rq.code};
      cell_writes++;
      cur_col++;
      if (cur_col >= cols) begin
        cur_col = 0;
        if (advance_row(nrows, line)) begin
          w[1].kind = KIND_CLR_LINE;
          w[1].line = LINE_W'(line);
          n = 2;
          line_clears++;
        end
      end
    end else if (rq.op == OP_CHAR && rq.code == CH_LF) begin
      cur_col = 0;
      if (advance_row(nrows, line)) begin
        w[0].kind = KIND_CLR_LINE;
        w[0].line = LINE_W'(line);
        line_clears++;
      end else begin
        w[0].kind = KIND_CURSOR;
      end
    end else begin
      if (rq.op == OP_CHAR) begin
        case (rq.code)
          CH_BS: begin
            if (cur_col > 0) cur_col--;
          end
          CH_CR: begin
            cur_col = 0;
          end
          CH_TAB: begin
            nc = ((cur_col >> ts) + 1) << ts;
            cur_col = (nc >= cols) ? cols - 1 : nc;
          end
          default: ;
        endcase
      end
      w[0].kind = KIND_CURSOR;
    end
    for (int k = 0; k < n; k++) begin
      w[k].col  = COL_W'(cur_col);
      w[k].row  = ROW_W'(cur_row);
      w[k].top  = LINE_W'(view_top_line);
      w[k].last = (k == n - 1);
      expected_words.push_back(w[k]);
    end
  endfunction

  function automatic request_t random_request();
    request_t    rq;
    int unsigned pick;
    rq = {2'($urandom_range(3)), 8'($urandom), 7'($urandom), 5'($urandom)};
    pick = $urandom_range(99);
    if (pick < 52) begin
      rq.op = OP_CHAR;
      rq.code = 8'($urandom_range(PRINT_HI, PRINT_LO));
    end else if (pick < 78) begin
      rq.op = OP_CHAR;
      case ($urandom_range(3))
        0: rq.code = CH_BS;
        1: rq.code = CH_TAB;
        2: rq.code = CH_LF;
        default: rq.code = CH_CR;
      endcase
    end else if (pick < 83) begin
      rq.op = OP_CHAR;
    end else if (pick < 94) begin
      rq.op = OP_SETPOS;
    end else if (pick < 97) begin
      rq.op = OP_CLEAR;
    end else begin
      rq.op = OP_NONE;
    end
    return rq;
  endfunction

  // sender: offers the next pending request unless it takes a random rest
  always @(posedge clk) begin : driver
    bit rest;
    rest = !steady && ($urandom_range(99) < 23);
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        console_step(on_bus);
        requests_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (pending_requests.size() > 0 && !rest) begin
          on_bus = pending_requests.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= {4'b0, on_bus.row, on_bus.col, on_bus.code};
          in_tuser  <= on_bus.op;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver readiness, with an occasional long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (holds_done != holds_asked) begin
      holds_done++;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= steady || ($urandom_range(99) >= 23);
    end
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin : monitor
    cell_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      words_seen++;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual kind %0d data 0x%0h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        want = expected_words.pop_front();
        check_field("kind",         want.kind, out_tuser);
        check_field("cell_address", want.addr, out_tdata[14:0]);
        check_field("cell_value",   want.val,  out_tdata[30:15]);
        check_field("line_index",   want.line, out_tdata[38:31]);
        check_field("cursor_col",   want.col,  out_tdata[45:39]);
        check_field("cursor_row",   want.row,  out_tdata[50:46]);
        check_field("view_top",     want.top,  out_tdata[58:51]);
        check_field("last",         want.last, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic push_req(logic [1:0] op, logic [7:0] code, logic [6:0] col, logic [4:0] row);
    pending_requests.push_back('{op: op, code: code, col: col, row: row});
  endtask

  // sampled away from the rising edge so that driver and monitor updates have settled
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_requests.size() != 0 || in_tvalid || expected_words.size() != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ATTR:      attr_reg = data;
      REG_TAB_SHIFT: tab_reg  = data[2:0];
      REG_COLUMNS:   cols_reg = data;
      REG_ROWS:      rows_reg = data[5:0];
      default: ;
    endcase
  endtask

  task automatic load_setup(logic [7:0] attr, logic [2:0] ts, logic [7:0] cols, logic [5:0] nrows);
    write_reg(REG_ATTR, attr);
    write_reg(REG_TAB_SHIFT, {5'b0, ts});
    write_reg(REG_COLUMNS, cols);
    write_reg(REG_ROWS, {2'b0, nrows});
  endtask

  task automatic run_random(int unsigned count);
    repeat (count) pending_requests.push_back(random_request());
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed sweep at reset geometry: 80 columns, 25 rows, tab stop 8
    push_req(OP_CLEAR,  8'h00,  7'd0,   5'd0);
    push_req(OP_CHAR,   PRINT_LO, 7'd0, 5'd0);
    push_req(OP_CHAR,   PRINT_HI, 7'h7f, 5'h1f);
    push_req(OP_CHAR,   8'h1f,  7'd0,   5'd0);
    push_req(OP_CHAR,   8'h7f,  7'd0,   5'd0);
    push_req(OP_CHAR,   8'hff,  7'h7f,  5'h1f);
    push_req(OP_CHAR,   8'h00,  7'd0,   5'd0);
    push_req(OP_CHAR,   CH_CR,  7'd0,   5'd0);
    push_req(OP_CHAR,   CH_BS,  7'd0,   5'd0);   // backspace pinned at column zero
    push_req(OP_CHAR,   CH_TAB, 7'd0,   5'd0);
    push_req(OP_CHAR,   CH_BS,  7'd0,   5'd0);
    push_req(OP_SETPOS, 8'hff,  7'h7f,  5'h1f);  // clamps to bottom right
    push_req(OP_CHAR,   CH_TAB, 7'd0,   5'd0);   // tab stop beyond the last column
    push_req(OP_CHAR,   8'h41,  7'd0,   5'd0);   // wrap and scroll: two words
    push_req(OP_SETPOS, 8'h00,  7'd79,  5'd0);
    push_req(OP_CHAR,   8'h42,  7'd0,   5'd0);   // wrap without scroll
    push_req(OP_SETPOS, 8'h00,  7'd5,   5'd24);
    push_req(OP_CHAR,   CH_LF,  7'd0,   5'd0);
    push_req(OP_CHAR,   CH_LF,  7'd0,   5'd0);
    push_req(OP_CHAR,   CH_LF,  7'h7f,  5'h1f);
    push_req(OP_NONE,   8'hff,  7'h7f,  5'h1f);
    push_req(OP_SETPOS, 8'hff,  7'd0,   5'd0);
    push_req(OP_CLEAR,  8'hff,  7'h7f,  5'h1f);
    wait_drained();

    // zero geometry acts as a single cell, oversized tab shift acts as 4
    load_setup(8'hff, 3'd7, 8'd0, 6'd0);
    run_random(60);
    wait_drained();

    // full geometry with a long receiver hold-off
    load_setup(8'h00, 3'd0, 8'd128, 6'd32);
    run_random(200);
    holds_asked++;
    wait_drained();

    // oversized geometry, no idling on either side
    load_setup(8'($urandom), 3'd4, 8'd255, 6'd63);
    steady = 1'b1;
    run_random(150);
    wait_drained();
    steady = 1'b0;

    load_setup(8'h5a, 3'd1, 8'd7, 6'd3);
    run_random(250);
    wait_drained();

    load_setup(8'($urandom), 3'd2, 8'd1, 6'd4);
    run_random(150);
    wait_drained();

    load_setup(8'($urandom), 3'd5, 8'd16, 6'd2);
    run_random(200);
    wait_drained();

    // random geometry, mostly small so that scrolling is frequent
    repeat (4) begin
      load_setup(8'($urandom), 3'($urandom),
                 ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(24)),
                 ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(6)));
      run_random(85);
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("requests %0d, words %0d: %0d cell writes, %0d scroll line clears, %0d screen clears",
             requests_taken, words_seen, cell_writes, line_clears, screen_clears);
    $display("geometries from one cell to oversized, long output hold-off, %0d errors", errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
